### rtl/kls_pkg.sv
// Package for the running Kth-largest selector.
// Holds the word type, the per-cell control struct and the register map.
// Depends on nothing.
package kls_pkg;

  // One stream word, two's complement
  typedef logic signed [31:0] value_t;

  // Control handed to every cell of the sorted chain
  typedef struct packed {
    logic load;     // a word is being inserted this cycle
    logic occ;      // this cell holds a kept value
    logic prev_ge;  // left neighbour holds a value >= the new word
  } cell_ctl_t;

  // Register map
  localparam int          PADDR_W       = 3;
  localparam int          KEEP_W        = 7;
  localparam logic        REG_KEEP_SLOT = 1'b0;  // word slot of keep_count
  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd1;

endpackage

### rtl/kth_largest_stream.sv
// Running Kth-largest selector: top level.
// Instantiates the sorted cell chain and the tail selector.
// Depends on kls_pkg, kls_cell, kls_tail_sel.
//
// Usage
//   Input channel: new_value with in_valid / in_stall. Output channel:
//   kth_largest and held_full with out_valid / out_stall. One output word
//   per input word, in order.
//   keep_count (K) is written over the APB port at byte address 0, while
//   the block is idle. K of zero acts as one, K above MAX_KEPT as MAX_KEPT.
//   Throughput: one word per cycle while in_stall is low. The chain of
//   MAX_KEPT compare cells inserts a word in the cycle it is accepted; the
//   tail selector then reads the last kept cell into the output register,
//   which raises out_valid, once that register is free.
//   A stalled receiver holds the output register; in_stall rises only while
//   a result is waiting behind a stalled output.
//   Reset: synchronous, clears the kept count, the pipeline flags and sets
//   K to 1. The cell contents are not cleared; only filled cells are read.
//   held_full is 1 once K values are held.
module kth_largest_stream import kls_pkg::*; #(
  parameter int MAX_KEPT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  value_t             new_value,
  output logic               out_valid,
  input  logic               out_stall,
  output value_t             kth_largest,
  output logic               held_full
);

  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam logic [10:0] MAX_WIDE = 11'(MAX_KEPT);

  logic [KEEP_W-1:0] keep_count;
  logic [CW-1:0]     total;
  logic [CW-1:0]     total_next;
  logic              pend;
  logic              pend_full;
  logic [10:0]       k_wide;
  logic [CW-1:0]     limit;
  logic [CW-1:0]     lim_m1;
  logic              take;
  logic              load_out;
  logic              discard;
  value_t            vals [MAX_KEPT];
  logic [MAX_KEPT-1:0] ge;
  value_t            tail;

  // APB register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEEP_SLOT) ? {{(32-KEEP_W){1'b0}}, keep_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_KEEP_SLOT) begin
      keep_count <= pwdata[KEEP_W-1:0];
    end
  end

  // effective K, clamped to 1..MAX_KEPT
  always_comb begin
    k_wide = {4'b0, keep_count};
    if (k_wide == 11'd0) begin
      k_wide = 11'd1;
    end else if (k_wide > MAX_WIDE) begin
      k_wide = MAX_WIDE;
    end
  end
  assign limit  = CW'(k_wide);
  assign lim_m1 = limit - 1'b1;

  // handshake: a result parked behind a stalled output blocks the input
  assign load_out = pend && (!out_valid || !out_stall);
  assign in_stall = pend && out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  // sorted chain of cells
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    cell_ctl_t ctl;
    value_t    prev_val;
    if (i == 0) begin : g_head
      assign ctl.prev_ge = 1'b0;
      assign prev_val    = new_value;
    end else begin : g_body
      assign ctl.prev_ge = ge[i-1];
      assign prev_val    = vals[i-1];
    end
    assign ctl.load = take;
    assign ctl.occ  = (total > CW'(i));

    kls_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_value (new_value),
      .prev_val  (prev_val),
      .val       (vals[i]),
      .ge        (ge[i])
    );
  end

  // word ranks below all K kept values when cell K-1 is still >= it
  assign discard = ge[lim_m1[IW-1:0]];

  // kept count after this insertion
  always_comb begin
    if (discard) begin
      total_next = (total > limit) ? limit : total;
    end else begin
      total_next = (total < limit) ? CW'(total + 1'b1) : limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      pend  <= 1'b0;
    end else begin
      if (take) begin
        total <= total_next;
      end
      if (take) begin
        pend <= 1'b1;
      end else if (load_out) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_full <= (total_next == limit);
    end
  end

  // tail read of the updated chain
  kls_tail_sel #(
    .N  (MAX_KEPT),
    .CW (CW)
  ) u_tail (
    .vals  (vals),
    .total (total),
    .tail  (tail)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kth_largest <= tail;
      held_full   <= pend_full;
    end
  end

endmodule

### rtl/kls_cell.sv
// One cell of the sorted chain: holds one kept value, largest first.
// Compares against the incoming word and takes either it or its left
// neighbour's value on insertion. Depends on kls_pkg.
module kls_cell import kls_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  value_t    new_value,
  input  value_t    prev_val,
  output value_t    val,
  output logic      ge
);

  // held value ranks at or above the incoming word
  assign ge = ctl.occ && (val >= new_value);

  // cells past the insertion point shift right; the first one takes the word
  always_ff @(posedge clk) begin
    if (ctl.load && !ge) begin
      val <= ctl.prev_ge ? new_value : prev_val;
    end
  end

endmodule

### rtl/kls_tail_sel.sv
// Picks the last kept value (entry total-1) out of the cell row.
// AND-OR select over all cells, one-hot on the fill count.
// Depends on kls_pkg.
module kls_tail_sel import kls_pkg::*; #(
  parameter int N  = 64,
  parameter int CW = 7
) (
  input  value_t          vals [N],
  input  logic [CW-1:0]   total,
  output value_t          tail
);

  value_t acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < N; i++) begin
      if (total == CW'(i + 1)) begin
        acc = acc | vals[i];
      end
    end
  end

  assign tail = acc;

endmodule

### rtl/kls_checker.sv
// Port-level checks for the running Kth-largest selector.
// Bound to kth_largest_stream; depends on kls_pkg.
module kls_checker import kls_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready,
  input logic               in_valid,
  input logic               in_stall,
  input value_t             new_value,
  input logic               out_valid,
  input logic               out_stall,
  input value_t             kth_largest,
  input logic               held_full
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kth_largest) && $stable(held_full))
    else $error("output word changed under stall");

  // a stalled input word is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(new_value))
    else $error("input word changed under stall");

  // input only backs up behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // keep_count reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == REG_KEEP_SLOT |=>
    (paddr[2] != REG_KEEP_SLOT) || (prdata[KEEP_W-1:0] == $past(pwdata[KEEP_W-1:0])))
    else $error("keep_count readback mismatch");

endmodule

bind kth_largest_stream kls_checker u_kls_checker (.*);

### verif/kth_largest_stream_tb.sv
// Self-checking testbench for kth_largest_stream, the running Kth-largest selector.
// Drives words and K settings; checks results against a sorted-list predictor or table values.
// Depends on kls_pkg and the kth_largest_stream RTL.
module kth_largest_stream_tb;
  import kls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_KEPT       = 64;
  localparam int HOLD_OFF       = 400;   // long receiver hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving
  localparam int DRAIN_PAD      = 4;     // idle pad after the last result, in cycles
  localparam int SEG_WORDS      = 64;
  localparam int NUM_SEGS       = 10;
  localparam int PRESSURE_SEG   = 4;

  localparam value_t V_MIN = 32'sh8000_0000;
  localparam value_t V_MAX = 32'sh7fff_ffff;

  typedef enum logic {ROW_WORD, ROW_SET_K} row_kind_t;

  // one row of the directed table; typed rows carry a known result
  typedef struct packed {
    row_kind_t         kind;
    value_t            word;
    logic [KEEP_W-1:0] k;
    logic              typed;
    value_t            kth;
    logic              full;
  } dir_row_t;

  typedef struct packed {
    value_t kth;
    logic   full;
  } kth_result_t;

  localparam int NUM_ROWS = 24;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    // K is 1 after reset: every word either replaces the top or is dropped
    '{ROW_WORD,  32'sd5,          7'd0,   1'b1, 32'sd5, 1'b1},
    '{ROW_WORD,  V_MIN,           7'd0,   1'b1, 32'sd5, 1'b1},
    '{ROW_WORD,  V_MAX,           7'd0,   1'b1, V_MAX,  1'b1},
    // K of zero behaves as one
    '{ROW_SET_K, 32'sd0,          7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  32'sd0,          7'd0,   1'b1, V_MAX,  1'b1},
    // K beyond the chain saturates; raising K keeps what is held
    '{ROW_SET_K, 32'sd0,          7'd127, 1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  V_MIN,           7'd0,   1'b1, V_MIN,  1'b0},
    '{ROW_SET_K, 32'sd0,          7'd4,   1'b0, 32'sd0, 1'b0},
    // equal words are kept as separate entries
    '{ROW_WORD,  32'sd7,          7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  32'sd7,          7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  32'sd7,          7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  -32'sd1,         7'd0,   1'b0, 32'sd0, 1'b0},
    // lowering K trims the list on the next word
    '{ROW_SET_K, 32'sd0,          7'd2,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  -32'sd2147483647, 7'd0,  1'b0, 32'sd0, 1'b0},
    '{ROW_SET_K, 32'sd0,          7'd64,  1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  32'sd3,          7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  -32'sd3,         7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  32'sh5555_5555,  7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  32'shAAAA_AAAA,  7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_SET_K, 32'sd0,          7'd1,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  -32'sd1,         7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_SET_K, 32'sd0,          7'd3,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  32'sd0,          7'd0,   1'b0, 32'sd0, 1'b0},
    '{ROW_WORD,  32'sd0,          7'd0,   1'b0, 32'sd0, 1'b0}
  };

  // K setting for the random segments but the last, which draws K at random; extremes included
  localparam logic [KEEP_W-1:0] SEG_K [NUM_SEGS] = '{
    7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd5, 7'd63, 7'd65, 7'd32, 7'd17
  };

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  value_t             new_value;
  logic               out_valid;
  logic               out_stall;
  value_t             kth_largest;
  logic               held_full;

  // predictor state: kept words, largest first
  value_t            kept_words [MAX_KEPT];
  int                kept_n;
  logic [KEEP_W-1:0] keep_k;

  kth_result_t kth_pending [$];
  int          send_idle_pct;
  int          stall_pct;
  bit          hold_off_req;
  int          words_in;
  int          results_seen;
  int          bad_words;
  int          k_writes;
  value_t      last_word;

  kth_largest_stream #(.MAX_KEPT(MAX_KEPT)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kth_largest (kth_largest),
    .held_full   (held_full)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // insert a word into the sorted list, trim to K, report the tail
  function automatic kth_result_t insert_and_select(input value_t v);
    kth_result_t res;
    int limit;
    int n;
    int pos;
    int last;
    limit = (keep_k == 0) ? 1 : ((keep_k > MAX_KEPT) ? MAX_KEPT : int'(keep_k));
    n     = kept_n;
    pos   = 0;
    while (pos < n && kept_words[pos] >= v) pos++;
    if (pos >= limit) begin
      if (n > limit) n = limit;
    end else begin
      last = (n < limit) ? n : limit - 1;
      for (int i = last; i > pos; i--) kept_words[i] = kept_words[i-1];
      kept_words[pos] = v;
      n = (n + 1 < limit) ? n + 1 : limit;
    end
    kept_n   = n;
    res.kth  = kept_words[n-1];
    res.full = (n == limit);
    return res;
  endfunction

  // random word: half full range, the rest extremes, clustered values and repeats
  function automatic value_t pick_word();
    value_t v;
    case ($urandom_range(0, 9))
      0:       v = V_MIN;
      1:       v = V_MAX;
      2, 3:    v = value_t'(int'($urandom_range(0, 16)) - 8);
      4:       v = last_word;
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  // offer one word and wait for it to be taken; called at a rising edge
  task automatic send_word(input value_t v, input logic typed, input kth_result_t known);
    bit          took;
    kth_result_t res;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    new_value <= v;
    do begin
      @(negedge clk);
      took = !in_stall;
      if (took) begin
        res = insert_and_select(v);
        if (typed) res = known;
        kth_pending = {kth_pending, res};
        words_in++;
        last_word = v;
      end
      @(posedge clk);
    end while (!took);
  endtask

  // APB write of keep_count; setup then access phase
  task automatic write_keep(input logic [KEEP_W-1:0] k);
    bit ready_seen;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_KEEP_SLOT, 2'b00};
    pwdata  <= {{(32-KEEP_W){1'b0}}, k};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready_seen = pready;
      @(posedge clk);
    end while (!ready_seen);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    keep_k  = k;
    k_writes++;
  endtask

  // stop offering, wait for every result, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (kth_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // result check, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    kth_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (kth_pending.size() == 0) begin
        $error("unexpected result word: kth_largest %0d held_full %0b", kth_largest, held_full);
        bad_words++;
      end else begin
        want = kth_pending.pop_front();
        if (kth_largest !== want.kth) begin
          $error("kth_largest: expected %0d, got %0d", want.kth, kth_largest);
          bad_words++;
        end
        if (held_full !== want.full) begin
          $error("held_full: expected %0b, got %0b", want.full, held_full);
          bad_words++;
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: timeout, %0d results outstanding", kth_pending.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    kth_result_t known;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    new_value     <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off_req  = 1'b0;
    words_in      = 0;
    results_seen  = 0;
    bad_words     = 0;
    k_writes      = 0;
    last_word     = '0;
    kept_n        = 0;
    keep_k        = KEEP_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_SET_K) begin
        drain();
        write_keep(DIR_ROWS[i].k);
      end else begin
        known.kth  = DIR_ROWS[i].kth;
        known.full = DIR_ROWS[i].full;
        send_word(DIR_ROWS[i].word, DIR_ROWS[i].typed, known);
      end
    end

    // random segments, cycling through the idling modes
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain();
      write_keep(seg == NUM_SEGS - 1 ? KEEP_W'($urandom_range(0, 127)) : SEG_K[seg]);
      case (seg % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 57; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      if (seg == PRESSURE_SEG) hold_off_req = 1'b1;
      known = '0;
      repeat (SEG_WORDS) send_word(pick_word(), 1'b0, known);
    end

    drain();
    $display("kth_largest_stream: %0d words sent, %0d results checked, %0d K writes",
             words_in, results_seen, k_writes);
    if (bad_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
